// File: sv/knap_pkg.sv
// Shared constants, types and state codes for the knapsack best-value block.
`default_nettype none
package knap_pkg;

    // Row geometry
    localparam int MAX_CAPACITY = 1024;
    localparam int ADDR_W       = $clog2(MAX_CAPACITY);
    localparam int CAP_LIM      = MAX_CAPACITY - 1;

    // Field widths
    localparam int WT_W  = 16;
    localparam int VAL_W = 16;
    localparam int SUM_W = 32;
    localparam int CAP_W = 10;

    // Register map
    localparam int             PADDR_W   = 3;
    localparam int             PDATA_W   = 32;
    localparam logic           REG_CAP   = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SUM_W-1:0]  t_sum;

    // Sweep sequencer states
    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SWEEP  = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_ANS_RD = 6'b010000,
        S_ANS_LD = 6'b100000
    } t_state;

    // Row memory access bundle
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_sum  wdata;
        t_addr raddr_a;
        t_addr raddr_b;
    } t_ram_req;

endpackage
`default_nettype wire

// File: sv/knap_if.sv
// Valid/ready channel interfaces for items and results.
`default_nettype none
interface knap_item_if;
    import knap_pkg::*;
    logic             valid;
    logic             ready;
    logic [WT_W-1:0]  item_weight;
    logic [VAL_W-1:0] item_value;
    logic             last_item;

    modport source (output valid, item_weight, item_value, last_item, input ready);
    modport sink   (input valid, item_weight, item_value, last_item, output ready);
endinterface

interface knap_res_if;
    import knap_pkg::*;
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] best_value;

    modport source (output valid, best_value, input ready);
    modport sink   (input valid, best_value, output ready);
endinterface
`default_nettype wire

// File: sv/knap_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module knap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, and register both reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

// File: sv/knap_cfg.sv
// APB-style register port holding the capacity in use.
`default_nettype none
module knap_cfg import knap_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [CAP_W-1:0]   o_cap
);

    logic             r_cap;
    logic [CAP_W-1:0] r_cap_val;
    logic             hit_cap;

    assign hit_cap = (paddr[PADDR_W-1:2] == REG_CAP);

    // Take the write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_val <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && hit_cap) begin
            r_cap_val <= pwdata[CAP_W-1:0];
        end
    end

    assign r_cap  = hit_cap;
    assign pready = 1'b1;
    assign prdata = r_cap ? {{(PDATA_W-CAP_W){1'b0}}, r_cap_val} : '0;
    assign o_cap  = r_cap_val;

endmodule
`default_nettype wire

// File: sv/knap_sweep.sv
// Row sweep sequencer: read-modify-write over the best-value row, answer and clear.
`default_nettype none
module knap_sweep import knap_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CAP_W-1:0] i_cap,
    knap_item_if.sink             i_item,
    knap_res_if.source            o_res,
    output t_ram_req              o_ram,
    input  wire t_sum             i_rdata_a,
    input  wire t_sum             i_rdata_b
);

    t_state           r_state, n_state;
    t_addr            r_c;
    t_addr            r_w;
    logic [VAL_W-1:0] r_v;
    logic             r_last;
    t_addr            r_cap;
    logic             r_pend;
    t_addr            r_wr_addr;
    t_addr            r_clr;
    logic             r_out_valid;
    t_sum             r_out_data;

    t_addr            eff_cap;
    logic [31:0]      cap32;
    logic             accept;
    logic             fits;
    logic             out_free;
    logic [SUM_W:0]   sum;
    t_sum             cand;

    // Clamp the capacity to the stored row
    assign cap32   = 32'(i_cap);
    assign eff_cap = (cap32 > 32'(CAP_LIM)) ? CAP_LIM[ADDR_W-1:0] : cap32[ADDR_W-1:0];
    assign fits    = 32'(i_item.item_weight) <= 32'(eff_cap);

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign out_free     = !r_out_valid || o_res.ready;

    // Candidate: best[c-w] + v, saturated
    assign sum  = {1'b0, i_rdata_b} + (SUM_W+1)'(r_v);
    assign cand = sum[SUM_W] ? '1 : sum[SUM_W-1:0];

    // Memory access: clearing pass or sweep reads and write-back.
    // The sweep runs downward, so reads at c-1 and c-1-w never touch the
    // entry being written back; no forwarding is needed.
    always_comb begin
        o_ram.raddr_a = (r_state == S_ANS_RD) ? r_cap : r_c;
        o_ram.raddr_b = r_c - r_w;
        if (r_state == S_CLEAR) begin
            o_ram.we    = 1'b1;
            o_ram.waddr = r_clr;
            o_ram.wdata = '0;
        end else begin
            o_ram.we    = r_pend && (cand > i_rdata_a);
            o_ram.waddr = r_wr_addr;
            o_ram.wdata = cand;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == CAP_LIM[ADDR_W-1:0]) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (fits)                     n_state = S_SWEEP;
                    else if (i_item.last_item)    n_state = S_ANS_RD;
                end
            end
            S_SWEEP: begin
                if (r_c == r_w) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = r_last ? S_ANS_RD : S_IDLE;
            end
            S_ANS_RD: begin
                if (out_free) n_state = S_ANS_LD;
            end
            S_ANS_LD: begin
                n_state = S_CLEAR;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == S_SWEEP);
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end else begin
                r_clr <= '0;
            end
            if (r_state == S_ANS_LD) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Latch the item and step the sweep index
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w    <= i_item.item_weight[ADDR_W-1:0];
            r_v    <= i_item.item_value;
            r_last <= i_item.last_item;
            r_cap  <= eff_cap;
            r_c    <= eff_cap;
        end else if (r_state == S_SWEEP) begin
            r_c <= r_c - 1'b1;
        end
        r_wr_addr <= r_c;
        if (r_state == S_ANS_LD) begin
            r_out_data <= i_rdata_a;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.best_value = r_out_data;

endmodule
`default_nettype wire

// File: sv/knapsack_01_max_value.sv
// Each accepted item that fits sweeps the row from the capacity down to its weight, one row
// entry per cycle, and the next item is held off until the sweep drains; an item heavier
// than the capacity is skipped without a sweep. After a last item the result is loaded once
// the output is free, then a clearing pass over all MAX_CAPACITY (1024) row entries holds
// off items. The row RAM's single write port sets the rate.
// Reset (synchronous, active low) sets capacity to 1023 and starts the clearing pass; items
// are held off until it ends, register writes are taken throughout.
`default_nettype none
module knapsack_01_max_value import knap_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    knap_item_if.sink               i_item,
    knap_res_if.source              o_res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic [CAP_W-1:0] cap;
    t_ram_req         ram_req;
    t_sum             rdata_a;
    t_sum             rdata_b;

    knap_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cap   (cap)
    );

    knap_sweep u_sweep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cap     (cap),
        .i_item    (i_item),
        .o_res     (o_res),
        .o_ram     (ram_req),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b)
    );

    knap_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_CAPACITY)
    ) u_row (
        .i_clk     (i_clk),
        .i_we      (ram_req.we),
        .i_waddr   (ram_req.waddr),
        .i_wdata   (ram_req.wdata),
        .i_raddr_a (ram_req.raddr_a),
        .i_raddr_b (ram_req.raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

endmodule
`default_nettype wire

// File: sv/knap_chk.sv
// Port-level assertions for the knapsack block, bound to the top level.
`default_nettype none
module knap_chk import knap_pkg::*; (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            i_in_ready,
    input wire logic [WT_W-1:0] i_in_weight,
    input wire logic            i_in_last,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready
);

    // Hold a result beat until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // A last item always makes the block busy
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("block ready right after a last item");

    // An item beyond any capacity is skipped and the input stays ready
    a_heavy_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_last && (i_in_weight[WT_W-1:CAP_W] != '0)
        |=> i_in_ready)
        else $error("heavy item stalled the input");

    // A result appears only while items are held off
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !i_in_ready)
        else $error("result raised while accepting items");

    // Reset empties the output and starts the clearing pass
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("reset left the block active");

endmodule

bind knapsack_01_max_value knap_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_weight (i_item.item_weight),
    .i_in_last   (i_item.last_item),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready)
);
`default_nettype wire
